// ===== rtl/core/dctf_pkg.sv =====
// ----------------------------------------------------------------------------
// dctf_pkg: shared types and constants of the 8-point forward DCT
// Widths of the butterfly, product and result words, the fixed-point
// constants of the flow graph and the enables that drive the output scalers.
// ----------------------------------------------------------------------------
package dctf_pkg;

	// Sample and constant precision
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_BITS   = 18;

	// Constant word: unsigned value below 2.0 carried as a signed word
	localparam int KW = FRAC_BITS + 2;

	// Butterfly growth: one bit per add level
	localparam int W1 = SAMPLE_BITS + 1;
	localparam int W2 = SAMPLE_BITS + 2;
	localparam int W3 = SAMPLE_BITS + 3;
	// Inner products and the pre-scale values, F fraction bits
	localparam int WP = W3 + KW;
	localparam int WV = WP + 3;
	// Output products, 2F fraction bits
	localparam int WR = WV + KW;

	// Input accept to result strobe, in clock cycles
	localparam int PIPE_DEPTH = 8;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [W1-1:0]          s1_t;
	typedef logic signed [W2-1:0]          s2_t;
	typedef logic signed [W3-1:0]          s3_t;
	typedef logic signed [WP-1:0]          p_t;
	typedef logic signed [WV-1:0]          val_t;
	typedef logic signed [WR-1:0]          prod_t;
	typedef logic signed [KW-1:0]          k_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	// Stage enables of an output scaler
	typedef struct packed {
		logic mul_en;
		logic out_en;
	} stage_en_t;

	// Round a 32-fraction-bit constant to FRAC_BITS, half up
	function automatic k_t kfix(input logic [63:0] q32);
		kfix = k_t'((q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	endfunction

	// Output scale factors
	localparam k_t K_OUT0 = kfix(64'd1518500250);
	localparam k_t K_OUT1 = kfix(64'd1094777670);
	localparam k_t K_OUT2 = kfix(64'd1162209775);
	localparam k_t K_OUT3 = kfix(64'd1291378312);
	localparam k_t K_OUT4 = K_OUT0;
	localparam k_t K_OUT5 = kfix(64'd1932684223);
	localparam k_t K_OUT6 = kfix(64'd2805822602);
	localparam k_t K_OUT7 = kfix(64'd5503819015);

	// Inner multipliers: cos(pi/4), and the three rotation terms
	localparam k_t K_SQRT_HALF = kfix(64'd3037000500);
	localparam k_t K_ROT_A     = kfix(64'd2324419551);
	localparam k_t K_ROT_B     = kfix(64'd5611645204);
	localparam k_t K_ROT_C     = kfix(64'd1643612827);

	// Rounding and saturation bounds on the output product
	localparam prod_t ROUND_HALF = prod_t'(64'd1 << (2 * FRAC_BITS - 1));
	localparam prod_t COEF_MAX   = prod_t'((2 ** (COEF_BITS - 1)) - 1);
	localparam prod_t COEF_MIN   = prod_t'(-(2 ** (COEF_BITS - 1)));

endpackage

// ===== rtl/core/dctf_scale.sv =====
// ----------------------------------------------------------------------------
// dctf_scale: output scaler of one coefficient
// Multiplies a pre-scale value by its output factor, then rounds to nearest
// (ties up) and saturates to the coefficient range. Two register stages.
// ----------------------------------------------------------------------------
module dctf_scale (
	input  logic                clk,
	input  dctf_pkg::stage_en_t en,
	input  dctf_pkg::val_t      val,
	input  dctf_pkg::k_t        k,
	output dctf_pkg::coef_t     coef
);

	dctf_pkg::prod_t prod_s7;
	dctf_pkg::prod_t rnd;
	dctf_pkg::coef_t coef_s8;

	// Scale the value by the output factor
	always_ff @(posedge clk) begin
		if (en.mul_en) begin
			prod_s7 <= dctf_pkg::prod_t'(val) * dctf_pkg::prod_t'(k);
		end
	end

	// Drop the fraction bits after adding one half
	assign rnd = (prod_s7 + dctf_pkg::ROUND_HALF) >>> (2 * dctf_pkg::FRAC_BITS);

	// Clamp to the coefficient range and hold
	always_ff @(posedge clk) begin
		if (en.out_en) begin
			priority if (rnd > dctf_pkg::COEF_MAX) begin
				coef_s8 <= dctf_pkg::coef_t'(dctf_pkg::COEF_MAX);
			end else if (rnd < dctf_pkg::COEF_MIN) begin
				coef_s8 <= dctf_pkg::coef_t'(dctf_pkg::COEF_MIN);
			end else begin
				coef_s8 <= dctf_pkg::coef_t'(rnd);
			end
		end
	end

	assign coef = coef_s8;

endmodule

// ===== rtl/core/dct8_forward_aan_top.sv =====
// ----------------------------------------------------------------------------
// dct8_forward_aan_top: 8-point orthonormal forward DCT-II
// Fast scaled flow graph: butterflies, five inner constant products and one
// output scale per coefficient, rounded to nearest and saturated to 18 bits.
// ----------------------------------------------------------------------------
// The block takes one item of eight samples in every clock cycle and returns
// its eight coefficients on coef_0 .. coef_7 with done; busy stays
// low, so start may be held high for a continuous stream. Latency is set by
// the eight register stages of the datapath: three butterfly levels, the
// inner constant products, two add levels and the output multiply with its
// rounding and clamp stage. done is high for one cycle with each result and
// the receiver cannot hold it off: coef_0 .. coef_7 must be captured in that
// cycle, since the next item may replace them in the one after.
// ----------------------------------------------------------------------------
module dct8_forward_aan_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dctf_pkg::sample_t sample_0,
	input  dctf_pkg::sample_t sample_1,
	input  dctf_pkg::sample_t sample_2,
	input  dctf_pkg::sample_t sample_3,
	input  dctf_pkg::sample_t sample_4,
	input  dctf_pkg::sample_t sample_5,
	input  dctf_pkg::sample_t sample_6,
	input  dctf_pkg::sample_t sample_7,
	output logic              done,
	output dctf_pkg::coef_t   coef_0,
	output dctf_pkg::coef_t   coef_1,
	output dctf_pkg::coef_t   coef_2,
	output dctf_pkg::coef_t   coef_3,
	output dctf_pkg::coef_t   coef_4,
	output dctf_pkg::coef_t   coef_5,
	output dctf_pkg::coef_t   coef_6,
	output dctf_pkg::coef_t   coef_7
);

	logic acc;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;

	// Stage 1: first butterfly level
	dctf_pkg::s1_t sa_s1, sb_s1, sc_s1, sd_s1, da_s1, db_s1, dc_s1, dd_s1;
	// Stage 2: second level
	dctf_pkg::s2_t ee_s2, ef_s2, eg_s2, eh_s2, ei_s2, ek_s2, dcb_s2;
	dctf_pkg::s1_t da_s2;
	// Stage 3: third level and first inner product
	dctf_pkg::s3_t lowdc_s3, lowac_s3, msum_s3, rsum_s3, eineg_s3;
	dctf_pkg::s2_t ek_s3, eh_s3;
	dctf_pkg::s1_t da_s3;
	dctf_pkg::p_t  ej_s3;
	// Stage 4: remaining inner products
	dctf_pkg::p_t  mid_s4, rot_s4, pn8_s4, p9_s4, ej_s4;
	dctf_pkg::s3_t lowdc_s4, lowac_s4;
	dctf_pkg::s2_t eh_s4;
	dctf_pkg::s1_t da_s4;
	// Stage 5: odd and even partial terms
	dctf_pkg::val_t odd1_s5, odd2_s5, even_a_s5, even_b_s5, odd_a_s5, odd_b_s5;
	dctf_pkg::val_t v0_s5, v4_s5;
	// Stage 6: pre-scale values
	dctf_pkg::val_t v_s6 [8];

	dctf_pkg::stage_en_t scl_en;

	assign busy = 1'b0;
	assign acc  = start && !busy;
	assign done = valid_s8;

	// Advance the valid bits with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// Sums and differences of mirrored samples
	always_ff @(posedge clk) begin
		if (acc) begin
			sa_s1 <= dctf_pkg::s1_t'(sample_0) + dctf_pkg::s1_t'(sample_7);
			sb_s1 <= dctf_pkg::s1_t'(sample_1) + dctf_pkg::s1_t'(sample_6);
			sc_s1 <= dctf_pkg::s1_t'(sample_2) + dctf_pkg::s1_t'(sample_5);
			sd_s1 <= dctf_pkg::s1_t'(sample_3) + dctf_pkg::s1_t'(sample_4);
			dd_s1 <= dctf_pkg::s1_t'(sample_3) - dctf_pkg::s1_t'(sample_4);
			dc_s1 <= dctf_pkg::s1_t'(sample_2) - dctf_pkg::s1_t'(sample_5);
			db_s1 <= dctf_pkg::s1_t'(sample_1) - dctf_pkg::s1_t'(sample_6);
			da_s1 <= dctf_pkg::s1_t'(sample_0) - dctf_pkg::s1_t'(sample_7);
		end
	end

	// Second butterfly level
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ee_s2  <= dctf_pkg::s2_t'(sa_s1) + dctf_pkg::s2_t'(sd_s1);
			ef_s2  <= dctf_pkg::s2_t'(sb_s1) + dctf_pkg::s2_t'(sc_s1);
			eg_s2  <= dctf_pkg::s2_t'(sb_s1) - dctf_pkg::s2_t'(sc_s1);
			eh_s2  <= dctf_pkg::s2_t'(sa_s1) - dctf_pkg::s2_t'(sd_s1);
			ei_s2  <= -dctf_pkg::s2_t'(dd_s1) - dctf_pkg::s2_t'(dc_s1);
			ek_s2  <= dctf_pkg::s2_t'(db_s1) + dctf_pkg::s2_t'(da_s1);
			dcb_s2 <= dctf_pkg::s2_t'(dc_s1) + dctf_pkg::s2_t'(db_s1);
			da_s2  <= da_s1;
		end
	end

	// Third level; scale the odd middle term
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			lowdc_s3 <= dctf_pkg::s3_t'(ee_s2) + dctf_pkg::s3_t'(ef_s2);
			lowac_s3 <= dctf_pkg::s3_t'(ee_s2) - dctf_pkg::s3_t'(ef_s2);
			msum_s3  <= dctf_pkg::s3_t'(eg_s2) + dctf_pkg::s3_t'(eh_s2);
			rsum_s3  <= dctf_pkg::s3_t'(ei_s2) + dctf_pkg::s3_t'(ek_s2);
			eineg_s3 <= -dctf_pkg::s3_t'(ei_s2);
			ej_s3    <= dctf_pkg::p_t'(dcb_s2) * dctf_pkg::p_t'(dctf_pkg::K_SQRT_HALF);
			ek_s3    <= ek_s2;
			eh_s3    <= eh_s2;
			da_s3    <= da_s2;
		end
	end

	// Even rotation and the odd rotation products
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			mid_s4   <= dctf_pkg::p_t'(msum_s3) * dctf_pkg::p_t'(dctf_pkg::K_SQRT_HALF);
			rot_s4   <= dctf_pkg::p_t'(rsum_s3) * dctf_pkg::p_t'(dctf_pkg::K_ROT_C);
			pn8_s4   <= dctf_pkg::p_t'(eineg_s3) * dctf_pkg::p_t'(dctf_pkg::K_ROT_A);
			p9_s4    <= dctf_pkg::p_t'(ek_s3) * dctf_pkg::p_t'(dctf_pkg::K_ROT_B);
			ej_s4    <= ej_s3;
			lowdc_s4 <= lowdc_s3;
			lowac_s4 <= lowac_s3;
			eh_s4    <= eh_s3;
			da_s4    <= da_s3;
		end
	end

	// Align integer terms to F fraction bits and form the partial terms
	always_ff @(posedge clk) begin
		if (valid_s4) begin
			odd1_s5   <= dctf_pkg::val_t'(pn8_s4) - dctf_pkg::val_t'(rot_s4);
			odd2_s5   <= dctf_pkg::val_t'(p9_s4) - dctf_pkg::val_t'(rot_s4);
			even_a_s5 <= (dctf_pkg::val_t'(eh_s4) <<< dctf_pkg::FRAC_BITS)
				+ dctf_pkg::val_t'(mid_s4);
			even_b_s5 <= (dctf_pkg::val_t'(eh_s4) <<< dctf_pkg::FRAC_BITS)
				- dctf_pkg::val_t'(mid_s4);
			odd_a_s5  <= (dctf_pkg::val_t'(da_s4) <<< dctf_pkg::FRAC_BITS)
				+ dctf_pkg::val_t'(ej_s4);
			odd_b_s5  <= (dctf_pkg::val_t'(da_s4) <<< dctf_pkg::FRAC_BITS)
				- dctf_pkg::val_t'(ej_s4);
			v0_s5     <= dctf_pkg::val_t'(lowdc_s4) <<< dctf_pkg::FRAC_BITS;
			v4_s5     <= dctf_pkg::val_t'(lowac_s4) <<< dctf_pkg::FRAC_BITS;
		end
	end

	// Combine into the eight pre-scale values
	always_ff @(posedge clk) begin
		if (valid_s5) begin
			v_s6[0] <= v0_s5;
			v_s6[1] <= odd_a_s5 + odd2_s5;
			v_s6[2] <= even_a_s5;
			v_s6[3] <= odd_b_s5 - odd1_s5;
			v_s6[4] <= v4_s5;
			v_s6[5] <= odd1_s5 + odd_b_s5;
			v_s6[6] <= even_b_s5;
			v_s6[7] <= odd_a_s5 - odd2_s5;
		end
	end

	assign scl_en.mul_en = valid_s6;
	assign scl_en.out_en = valid_s7;

	// Output scale, round and clamp per coefficient
	dctf_scale u_scl0 (.clk(clk), .en(scl_en), .val(v_s6[0]), .k(dctf_pkg::K_OUT0), .coef(coef_0));
	dctf_scale u_scl1 (.clk(clk), .en(scl_en), .val(v_s6[1]), .k(dctf_pkg::K_OUT1), .coef(coef_1));
	dctf_scale u_scl2 (.clk(clk), .en(scl_en), .val(v_s6[2]), .k(dctf_pkg::K_OUT2), .coef(coef_2));
	dctf_scale u_scl3 (.clk(clk), .en(scl_en), .val(v_s6[3]), .k(dctf_pkg::K_OUT3), .coef(coef_3));
	dctf_scale u_scl4 (.clk(clk), .en(scl_en), .val(v_s6[4]), .k(dctf_pkg::K_OUT4), .coef(coef_4));
	dctf_scale u_scl5 (.clk(clk), .en(scl_en), .val(v_s6[5]), .k(dctf_pkg::K_OUT5), .coef(coef_5));
	dctf_scale u_scl6 (.clk(clk), .en(scl_en), .val(v_s6[6]), .k(dctf_pkg::K_OUT6), .coef(coef_6));
	dctf_scale u_scl7 (.clk(clk), .en(scl_en), .val(v_s6[7]), .k(dctf_pkg::K_OUT7), .coef(coef_7));

endmodule

// ===== rtl/core/dctf_checker.sv =====
// ----------------------------------------------------------------------------
// dctf_checker: port-level checks of the forward DCT
// Watches start, busy, done and the payload ports for latency and a zero item.
// ----------------------------------------------------------------------------
module dctf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input dctf_pkg::sample_t sample_0,
	input dctf_pkg::sample_t sample_1,
	input dctf_pkg::sample_t sample_2,
	input dctf_pkg::sample_t sample_3,
	input dctf_pkg::sample_t sample_4,
	input dctf_pkg::sample_t sample_5,
	input dctf_pkg::sample_t sample_6,
	input dctf_pkg::sample_t sample_7,
	input logic              done,
	input dctf_pkg::coef_t   coef_0,
	input dctf_pkg::coef_t   coef_1,
	input dctf_pkg::coef_t   coef_2,
	input dctf_pkg::coef_t   coef_3,
	input dctf_pkg::coef_t   coef_4,
	input dctf_pkg::coef_t   coef_5,
	input dctf_pkg::coef_t   coef_6,
	input dctf_pkg::coef_t   coef_7
);

	localparam int Lat = dctf_pkg::PIPE_DEPTH;

	logic zero_in;
	logic zero_out;

	assign zero_in = (sample_0 == '0) && (sample_1 == '0) && (sample_2 == '0)
		&& (sample_3 == '0) && (sample_4 == '0) && (sample_5 == '0)
		&& (sample_6 == '0) && (sample_7 == '0);
	assign zero_out = (coef_0 == '0) && (coef_1 == '0) && (coef_2 == '0)
		&& (coef_3 == '0) && (coef_4 == '0) && (coef_5 == '0)
		&& (coef_6 == '0) && (coef_7 == '0);

	// The pipeline never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a stall-free pipeline");

	// Every taken item comes out after the pipeline depth
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Lat done)
		else $error("taken item did not produce a result on time");

	// No result without an item taken the pipeline depth earlier
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Lat))
		else $error("result strobe without a matching item");

	// An all-zero item transforms to all-zero coefficients
	a_zero_item: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(zero_in, Lat)) |-> zero_out)
		else $error("zero item gave a nonzero coefficient");

endmodule

bind dct8_forward_aan_top dctf_checker u_dctf_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 8-point forward DCT
// Drives sample vectors at the falling edge with random gaps, predicts each
// item's eight coefficients in fixed point and compares every result field
// at the rising edge when done is high.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int F              = dctf_pkg::FRAC_BITS;

	// Flow-graph constants, rounded half up from 32 fraction bits
	localparam longint HALF_Q = longint'(1) << (31 - F);
	localparam longint C_SC0  = (longint'(64'd1518500250) + HALF_Q) >>> (32 - F);
	localparam longint C_SC1  = (longint'(64'd1094777670) + HALF_Q) >>> (32 - F);
	localparam longint C_SC2  = (longint'(64'd1162209775) + HALF_Q) >>> (32 - F);
	localparam longint C_SC3  = (longint'(64'd1291378312) + HALF_Q) >>> (32 - F);
	localparam longint C_SC5  = (longint'(64'd1932684223) + HALF_Q) >>> (32 - F);
	localparam longint C_SC6  = (longint'(64'd2805822602) + HALF_Q) >>> (32 - F);
	localparam longint C_SC7  = (longint'(64'd5503819015) + HALF_Q) >>> (32 - F);
	localparam longint C_R2   = (longint'(64'd3037000500) + HALF_Q) >>> (32 - F);
	localparam longint C_RA   = (longint'(64'd2324419551) + HALF_Q) >>> (32 - F);
	localparam longint C_RB   = (longint'(64'd5611645204) + HALF_Q) >>> (32 - F);
	localparam longint C_RC   = (longint'(64'd1643612827) + HALF_Q) >>> (32 - F);

	typedef logic [7:0][dctf_pkg::SAMPLE_BITS-1:0] block_t;
	typedef logic [7:0][dctf_pkg::COEF_BITS-1:0]   coefs_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              busy;
	dctf_pkg::sample_t sample_0 = '0;
	dctf_pkg::sample_t sample_1 = '0;
	dctf_pkg::sample_t sample_2 = '0;
	dctf_pkg::sample_t sample_3 = '0;
	dctf_pkg::sample_t sample_4 = '0;
	dctf_pkg::sample_t sample_5 = '0;
	dctf_pkg::sample_t sample_6 = '0;
	dctf_pkg::sample_t sample_7 = '0;
	logic              done;
	dctf_pkg::coef_t   coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7;

	block_t pending_blocks[$];
	coefs_t pending_coefs[$];
	int     mismatches   = 0;
	int     gap_left     = 0;
	int     stall_cycles = 0;
	bit     item_taken   = 1'b0;

	dct8_forward_aan_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sample_0 (sample_0),
		.sample_1 (sample_1),
		.sample_2 (sample_2),
		.sample_3 (sample_3),
		.sample_4 (sample_4),
		.sample_5 (sample_5),
		.sample_6 (sample_6),
		.sample_7 (sample_7),
		.done     (done),
		.coef_0   (coef_0),
		.coef_1   (coef_1),
		.coef_2   (coef_2),
		.coef_3   (coef_3),
		.coef_4   (coef_4),
		.coef_5   (coef_5),
		.coef_6   (coef_6),
		.coef_7   (coef_7)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scale by an output factor, round half toward plus infinity, clamp to 18 bits
	function automatic logic [dctf_pkg::COEF_BITS-1:0] scale_round_sat(input longint v,
			input longint k);
		longint r;
		longint top;
		top = (longint'(1) << (dctf_pkg::COEF_BITS - 1)) - 1;
		r = (v * k + (longint'(1) << (2 * F - 1))) >>> (2 * F);
		if (r > top)
			r = top;
		if (r < -top - 1)
			r = -top - 1;
		return r[dctf_pkg::COEF_BITS-1:0];
	endfunction

	// Fixed-point coefficients of one sample vector
	function automatic coefs_t dct8_coefs(input block_t blk);
		longint x[8];
		longint one;
		longint sa, sb, sc, sd, da, db, dc, dd;
		longint ee, ef, eg, eh, ei, ej, ek;
		longint lowdc, lowac, rot, mid, odd1, odd2;
		longint even_a, even_b, odd_a, odd_b;
		coefs_t c;
		one = longint'(1) << F;
		for (int i = 0; i < 8; i++)
			x[i] = longint'($signed(blk[i]));

		// First butterfly level
		sa = x[0] + x[7]; sb = x[1] + x[6]; sc = x[2] + x[5]; sd = x[3] + x[4];
		dd = x[3] - x[4]; dc = x[2] - x[5]; db = x[1] - x[6]; da = x[0] - x[7];

		// Even and odd halves, inner products with F fraction bits
		ee = sa + sd;
		ef = sb + sc;
		eg = sb - sc;
		eh = sa - sd;
		ei = -dd - dc;
		ej = (dc + db) * C_R2;
		ek = db + da;

		lowdc = ee + ef;
		lowac = ee - ef;
		mid   = (eg + eh) * C_R2;
		rot   = (ei + ek) * C_RC;
		odd1  = -ei * C_RA - rot;
		odd2  = ek * C_RB - rot;

		even_a = mid + eh * one;
		even_b = eh * one - mid;
		odd_a  = ej + da * one;
		odd_b  = da * one - ej;

		// Output scaling
		c[0] = scale_round_sat(lowdc * one, C_SC0);
		c[1] = scale_round_sat(odd_a + odd2, C_SC1);
		c[2] = scale_round_sat(even_a, C_SC2);
		c[3] = scale_round_sat(odd_b - odd1, C_SC3);
		c[4] = scale_round_sat(lowac * one, C_SC0);
		c[5] = scale_round_sat(odd1 + odd_b, C_SC5);
		c[6] = scale_round_sat(even_b, C_SC6);
		c[7] = scale_round_sat(odd_a - odd2, C_SC7);
		return c;
	endfunction

	// Accept items, check results, watch for a hang
	always @(posedge clk) begin
		coefs_t got;
		coefs_t want;
		item_taken = 1'b0;
		if (arst_n) begin
			item_taken = start && !busy;
			if (item_taken)
				pending_coefs.push_back(dct8_coefs({sample_7, sample_6, sample_5,
					sample_4, sample_3, sample_2, sample_1, sample_0}));
			if (done) begin
				got = {coef_7, coef_6, coef_5, coef_4, coef_3, coef_2, coef_1, coef_0};
				if (pending_coefs.size() == 0) begin
					$error("result with no item outstanding");
					mismatches++;
				end else begin
					want = pending_coefs.pop_front();
					for (int i = 0; i < 8; i++) begin
						if (got[i] !== want[i]) begin
							$error("coef_%0d: expected %0d, got %0d", i,
								$signed(want[i]), $signed(got[i]));
							mismatches++;
						end
					end
				end
			end
			if (item_taken || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Drive the next item at the falling edge, with random gaps between items
	always @(negedge clk) begin
		int r;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !item_taken) begin
			// hold the item until it is taken
		end else if (gap_left != 0) begin
			start <= 1'b0;
			gap_left--;
		end else if (pending_blocks.size() != 0) begin
			{sample_7, sample_6, sample_5, sample_4,
				sample_3, sample_2, sample_1, sample_0} <= pending_blocks.pop_front();
			start <= 1'b1;
			r = $urandom_range(0, 99);
			if (r < 60)
				gap_left = 0;
			else if (r < 92)
				gap_left = $urandom_range(1, 3);
			else
				gap_left = $urandom_range(8, 40);
		end else begin
			start <= 1'b0;
		end
	end

	initial begin
		block_t blk;
		int     mode;

		// Zeros, extremes and alternating signs
		blk = '0;
		pending_blocks.push_back(blk);
		pending_blocks.push_back({8{16'h7fff}});
		pending_blocks.push_back({8{16'h8000}});
		pending_blocks.push_back({4{16'h8000, 16'h7fff}});
		pending_blocks.push_back({4{16'h7fff, 16'h8000}});
		pending_blocks.push_back({4{16'h5555, 16'haaaa}});

		// Single impulse at each position
		for (int i = 0; i < 8; i++) begin
			blk = '0;
			blk[i] = i[0] ? 16'h8000 : 16'h7fff;
			pending_blocks.push_back(blk);
		end

		// Exact half on the DC and mid coefficients, both signs
		pending_blocks.push_back({8{16'h0800}});
		pending_blocks.push_back({8{16'hf800}});
		pending_blocks.push_back({16'h0800, 16'hf800, 16'hf800, 16'h0800,
			16'h0800, 16'hf800, 16'hf800, 16'h0800});
		pending_blocks.push_back({16'hf800, 16'h0800, 16'h0800, 16'hf800,
			16'hf800, 16'h0800, 16'h0800, 16'hf800});

		// Random vectors: full range, small values, extremes mixed in, flat
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mode = $urandom_range(0, 9);
			for (int i = 0; i < 8; i++) begin
				case (mode)
					6, 7: blk[i] = dctf_pkg::SAMPLE_BITS'($urandom_range(0, 127)) - 16'd64;
					8: begin
						case ($urandom_range(0, 2))
							0: blk[i] = 16'h7fff;
							1: blk[i] = 16'h8000;
							default: blk[i] = dctf_pkg::SAMPLE_BITS'($urandom);
						endcase
					end
					9: blk[i] = (i == 0) ? dctf_pkg::SAMPLE_BITS'($urandom) : blk[0];
					default: blk[i] = dctf_pkg::SAMPLE_BITS'($urandom);
				endcase
			end
			pending_blocks.push_back(blk);
		end

		// Hold reset, then release it at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain, then let the pipeline settle
		@(negedge clk);
		while (pending_blocks.size() != 0 || start || pending_coefs.size() != 0)
			@(negedge clk);
		repeat (2 * dctf_pkg::PIPE_DEPTH) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
